[rtl/bfdh_pkg.sv]
// Package for the double-hash bloom filter: sizes, state type, hash steps and
// controller/datapath command structs. No dependencies.
package bfdh_pkg;

	localparam int unsigned MAX_BITS_DEF   = 65536;
	localparam int unsigned MAX_PROBES_DEF = 16;
	localparam int unsigned KEY_W          = 64;
	localparam int unsigned BITCNT_W       = 17;
	localparam int unsigned PROBECNT_W     = 5;
	localparam logic [BITCNT_W-1:0]   BITCNT_RST   = 17'd65536;
	localparam logic [PROBECNT_W-1:0] PROBECNT_RST = 5'd5;
	localparam logic REG_BIT_COUNT   = 1'b0;
	localparam logic REG_PROBE_COUNT = 1'b1;
	localparam logic ACT_INSERT = 1'b0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_REDUCE,
		ST_PROBE,
		ST_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic hash_step;
		logic red_step;
		logic probe_rd;
		logic probe_next;
		logic probe_wr;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hash_done;
		logic red_done;
		logic probes_done;
		logic bit_set;
		logic is_insert;
	} sts_t;

	// one mixing step per cycle, steps 0 to 6
	function automatic logic [63:0] mix_a_step(input logic [63:0] v, input logic [2:0] s);
		case (s)
			3'd0: return (~v) + (v << 21);
			3'd1: return v ^ (v >> 24);
			3'd2: return (v + (v << 3)) + (v << 8);
			3'd3: return v ^ (v >> 14);
			3'd4: return (v + (v << 2)) + (v << 4);
			3'd5: return v ^ (v >> 28);
			3'd6: return v + (v << 31);
			default: return v;
		endcase
	endfunction

	function automatic logic [63:0] mix_b_step(input logic [63:0] v, input logic [2:0] s);
		case (s)
			3'd0: return (~v) + (v << 18);
			3'd1: return v ^ (v >> 31);
			3'd2: return (v + (v << 8)) + (v << 12);
			3'd3: return v ^ (v >> 22);
			3'd4: return (v + (v << 2)) + (v << 7);
			3'd5: return v ^ (v >> 24);
			3'd6: return v + (v << 15);
			default: return v;
		endcase
	endfunction

endpackage

[rtl/bfdh_ctrl.sv]
// Controller state machine for the bloom filter.
// Depends on bfdh_pkg.
module bfdh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  bfdh_pkg::sts_t sts,
	output bfdh_pkg::cmd_t cmd,
	output logic           idle
);
	import bfdh_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		idle      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				idle     = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_done) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				cmd.red_step = 1'b1;
				if (sts.red_done) state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (sts.probes_done) begin
					state_d = sts.is_insert ? ST_IDLE : ST_RESULT;
				end else begin
					cmd.probe_rd = 1'b1;
					state_d      = ST_WAIT;
				end
			end
			ST_WAIT: begin
				// read data of the byte is registered now
				if (sts.is_insert) begin
					cmd.probe_wr   = 1'b1;
					cmd.probe_next = 1'b1;
					state_d        = ST_PROBE;
				end else if (!sts.bit_set) begin
					state_d = ST_RESULT;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = ST_PROBE;
				end
			end
			ST_RESULT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule

[rtl/bfdh_dp.sv]
// Datapath: hashes, two restoring modulo reducers, probe stepper, byte store.
// Depends on bfdh_pkg.
module bfdh_dp #(
	parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
	parameter int unsigned MAX_PROBES = bfdh_pkg::MAX_PROBES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            action,
	input  logic [bfdh_pkg::KEY_W-1:0]      key,
	input  logic [bfdh_pkg::BITCNT_W-1:0]   bit_count_q,
	input  logic [bfdh_pkg::PROBECNT_W-1:0] probe_count_q,
	input  bfdh_pkg::cmd_t                  cmd,
	output bfdh_pkg::sts_t                  sts,
	output logic                            present
);
	import bfdh_pkg::*;

	localparam int unsigned BYTES = (MAX_BITS + 7) / 8;
	localparam int unsigned AW    = (BYTES > 1) ? $clog2(BYTES) : 1;
	localparam int unsigned PW    = $clog2(MAX_BITS + 1);
	localparam int unsigned MW    = (PW > BITCNT_W) ? PW : BITCNT_W;
	localparam int unsigned KW    = $clog2(MAX_PROBES + 1);
	localparam int unsigned CW    = 7;
	localparam logic [MW-1:0] MAXB = MW'(MAX_BITS);
	localparam logic [AW-1:0] LAST = AW'(BYTES - 1);

	logic [7:0] mem [BYTES];
	logic [7:0] rd_q;
	logic [AW-1:0] clr_q;
	logic [MW-1:0] m_q;
	logic [KW-1:0] k_q, i_q;
	logic [63:0] ha_q, hb_q;
	logic [2:0] hs_q;
	logic [MW-1:0] ra_q, rb_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] pos_q;
	logic ins_q;
	logic [MW-1:0] m_d, ra_n, rb_n, pos_n;
	logic [MW:0] ta, tb, ps;
	logic [KW-1:0] k_d;

	always_comb begin
		m_d = MW'(bit_count_q);
		if (bit_count_q == '0) m_d = MW'(1);
		if (MW'(bit_count_q) > MAXB) m_d = MAXB;
		k_d = (32'(probe_count_q) > MAX_PROBES) ? KW'(MAX_PROBES) : KW'(probe_count_q);
		ta = {ra_q, ha_q[63]};
		tb = {rb_q, hb_q[63]};
		ra_n = (ta >= {1'b0, m_q}) ? MW'(ta - {1'b0, m_q}) : ta[MW-1:0];
		rb_n = (tb >= {1'b0, m_q}) ? MW'(tb - {1'b0, m_q}) : tb[MW-1:0];
		ps = {1'b0, pos_q} + {1'b0, rb_q};
		pos_n = (ps >= {1'b0, m_q}) ? MW'(ps - {1'b0, m_q}) : ps[MW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cnt_q <= '0;
			hs_q  <= '0;
			i_q   <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.load) begin
				cnt_q <= '0;
				hs_q  <= '0;
				i_q   <= '0;
			end
			if (cmd.hash_step) hs_q <= hs_q + 3'd1;
			if (cmd.red_step) cnt_q <= cnt_q + CW'(1);
			if (cmd.probe_next) i_q <= i_q + KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ha_q  <= key;
			hb_q  <= key;
			ra_q  <= '0;
			rb_q  <= '0;
			m_q   <= m_d;
			k_q   <= k_d;
			ins_q <= (action == ACT_INSERT);
		end
		if (cmd.hash_step) begin
			ha_q <= mix_a_step(ha_q, hs_q);
			hb_q <= mix_b_step(hb_q, hs_q);
		end
		if (cmd.red_step) begin
			ra_q <= ra_n;
			rb_q <= rb_n;
			ha_q <= {ha_q[62:0], 1'b0};
			hb_q <= {hb_q[62:0], 1'b0};
			if (cnt_q == CW'(63)) pos_q <= ra_n;
		end
		if (cmd.probe_next) pos_q <= pos_n;
	end

	// byte store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step) mem[clr_q] <= 8'h00;
		else if (cmd.probe_wr) mem[pos_q[AW+2:3]] <= rd_q | (8'h01 << pos_q[2:0]);
		if (cmd.probe_rd) rd_q <= mem[pos_q[AW+2:3]];
	end

	assign sts.clr_done    = (clr_q == LAST);
	assign sts.hash_done   = (hs_q == 3'd6);
	assign sts.red_done    = (cnt_q == CW'(63));
	assign sts.probes_done = (i_q == k_q);
	assign sts.bit_set     = rd_q[pos_q[2:0]];
	assign sts.is_insert   = ins_q;
	// a query stops early at a clear bit, so all probes done means present
	assign present         = sts.probes_done;
endmodule

[rtl/bfdh_cfg.sv]
// Configuration registers for bit and probe counts.
// Depends on bfdh_pkg.
module bfdh_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [31:0]                     cfg_index,
	input  logic [31:0]                     cfg_data,
	output logic [bfdh_pkg::BITCNT_W-1:0]   bit_count_q,
	output logic [bfdh_pkg::PROBECNT_W-1:0] probe_count_q
);
	import bfdh_pkg::*;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q   <= BITCNT_RST;
			probe_count_q <= PROBECNT_RST;
		end else if (cfg_valid && cfg_index[31:1] == '0) begin
			if (cfg_index[0] == REG_BIT_COUNT) bit_count_q <= cfg_data[BITCNT_W-1:0];
			if (cfg_index[0] == REG_PROBE_COUNT) probe_count_q <= cfg_data[PROBECNT_W-1:0];
		end
	end
endmodule

[rtl/bloom_filter_double_hash.sv]
// Bloom filter over 64-bit keys with double hashing. After reset the byte
// store is cleared before the first item is taken. An item is then accepted,
// mixed by seven hash steps (one step per cycle), reduced by 64 steps of
// bit-serial modulo reduction of both hashes, probed (each probe a registered
// store read, then a write or a test) and finished. No new item is taken
// until the filter is back in idle; a query stops at the first clear bit and
// holds its result until taken.
module bloom_filter_double_hash #(
	parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
	parameter int unsigned MAX_PROBES = bfdh_pkg::MAX_PROBES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [63:0] key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        present,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import bfdh_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle;
	logic pres_raw;
	logic [BITCNT_W-1:0] bit_count_q;
	logic [PROBECNT_W-1:0] probe_count_q;

	bfdh_cfg u_cfg (.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.bit_count_q, .probe_count_q);

	bfdh_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd, .idle);

	bfdh_dp #(.MAX_BITS(MAX_BITS), .MAX_PROBES(MAX_PROBES)) u_dp (.clk, .arst_n,
		.action, .key, .bit_count_q, .probe_count_q, .cmd, .sts, .present(pres_raw));

	assign present = pres_raw;

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.hash_step, cmd.red_step, cmd.probe_rd,
			cmd.clr_step}) <= 1)
		else $error("overlapping datapath commands");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> idle) else $error("accept outside idle");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_wr |-> $past(cmd.probe_rd)) else $error("write without read");
endmodule

[bench/tb_bloom_filter_double_hash.sv]
// Self-checking bench for bloom_filter_double_hash: directed table, then random inserts
// and queries under several idle/stall mixes, checked against an in-bench filter model.
// Depends on rtl/bfdh_pkg.sv and rtl/bloom_filter_double_hash.sv.
module tb_bloom_filter_double_hash;
	timeunit 1ns;
	timeprecision 1ps;

	import bfdh_pkg::*;

	localparam int unsigned FILTER_BITS  = 65536;
	localparam int unsigned PROBE_LIMIT  = 16;
	localparam logic [31:0] CFG_BITS     = 32'd0;
	localparam logic [31:0] CFG_PROBES   = 32'd1;
	localparam logic [31:0] CFG_NO_REG   = 32'd7;
	localparam logic        ACT_QUERY    = 1'b1;
	localparam int unsigned SETTLE_CYC   = 160;
	localparam int unsigned WATCHDOG_CYC = 40000;
	localparam int unsigned HOLD_CYC     = 3000;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		logic        act;
		logic [63:0] k;
		logic [31:0] idx;
		logic [31:0] data;
		bit          typed;
		logic        want;
	} dir_row_t;

	logic        clk, arst_n;
	logic        in_valid, in_stall, action, out_valid, out_stall, present;
	logic [63:0] key;
	logic        cfg_valid, cfg_ready;
	logic [31:0] cfg_index, cfg_data;

	// model of the filter and its registers
	bit          filter_map [FILTER_BITS];
	logic [16:0] bits_reg;
	logic [4:0]  probes_reg;
	logic        answers_due [$];
	logic [63:0] inserted_keys [$];
	dir_row_t    dir_rows [$];

	bit          typed_chk;
	logic        typed_val;
	int unsigned gap_pct, stall_pct, hold_left;
	int unsigned errors, n_items, n_queries, n_hits, n_cfg, idle_cnt;

	bloom_filter_double_hash i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .key(key),
		.out_valid(out_valid), .out_stall(out_stall), .present(present),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] hash_first(input logic [63:0] x);
		logic [63:0] v;
		v = (~x) + (x << 21);
		v = v ^ (v >> 24);
		v = (v + (v << 3)) + (v << 8);
		v = v ^ (v >> 14);
		v = (v + (v << 2)) + (v << 4);
		v = v ^ (v >> 28);
		return v + (v << 31);
	endfunction

	function automatic logic [63:0] hash_second(input logic [63:0] x);
		logic [63:0] v;
		v = (~x) + (x << 18);
		v = v ^ (v >> 31);
		v = (v + (v << 8)) + (v << 12);
		v = v ^ (v >> 22);
		v = (v + (v << 2)) + (v << 7);
		v = v ^ (v >> 24);
		return v + (v << 15);
	endfunction

	// Applies one item to the filter model; returns the query answer.
	function automatic logic filter_access(input logic act, input logic [63:0] k);
		logic [63:0] m, nprobe, base, stride, pos;
		logic        hit;
		m = 64'(bits_reg);
		if (m == 0) m = 1;
		if (m > FILTER_BITS) m = FILTER_BITS;
		nprobe = 64'(probes_reg);
		if (nprobe > PROBE_LIMIT) nprobe = PROBE_LIMIT;
		base   = hash_first(k) % m;
		stride = hash_second(k) % m;
		hit    = 1'b1;
		for (int unsigned i = 0; i < nprobe; i++) begin
			pos = (base + i * stride) % m;
			if (act == ACT_INSERT) begin
				filter_map[pos[15:0]] = 1'b1;
			end else if (!filter_map[pos[15:0]]) begin
				hit = 1'b0;
				break;
			end
		end
		return hit;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			logic ans;
			ans = filter_access(action, key);
			n_items++;
			if (action == ACT_QUERY)
				answers_due.push_back(typed_chk ? typed_val : ans);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			logic want;
			n_hits += present;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result, present=%0b", $time, present);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (present !== want) begin
					$display("%0t: present mismatch, expected %0b got %0b",
						$time, want, present);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= WATCHDOG_CYC) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cnt);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: a requested hold-off first, otherwise random stall
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic offer_item(input logic act, input logic [63:0] k, input bit chk,
			input logic want);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		action    = act;
		key       = k;
		typed_chk = chk;
		typed_val = want;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (act == ACT_INSERT) inserted_keys.push_back(k);
		if (inserted_keys.size() > 64) void'(inserted_keys.pop_front());
		n_queries += (act == ACT_QUERY);
	endtask

	// wait until all answers are in, then let a trailing insert finish
	task automatic settle();
		in_valid = 1'b0;
		while (answers_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input logic [31:0] idx, input logic [31:0] data);
		settle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_BITS) bits_reg = data[16:0];
		else if (idx == CFG_PROBES) probes_reg = data[4:0];
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic void add_item(input logic act, input logic [63:0] k, input bit chk,
			input logic want);
		dir_rows.push_back('{ROW_ITEM, act, k, 32'd0, 32'd0, chk, want});
	endfunction

	function automatic void add_cfg(input logic [31:0] idx, input logic [31:0] data);
		dir_rows.push_back('{ROW_CFG, ACT_INSERT, 64'd0, idx, data, 1'b0, 1'b0});
	endfunction

	function automatic logic [31:0] pick_bits();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'd1;
			2: return FILTER_BITS;
			3: return $urandom_range(2, 64);
			4: return $urandom_range(65, 4096);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [63:0] k;
		logic        act;
		clk = 1'b0; arst_n = 1'b0;
		in_valid = 1'b0; action = ACT_INSERT; key = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		typed_chk = 1'b0; typed_val = 1'b0;
		gap_pct = 0; stall_pct = 0; hold_left = 0;
		errors = 0; n_items = 0; n_queries = 0; n_hits = 0; n_cfg = 0; idle_cnt = 0;
		bits_reg = BITCNT_RST; probes_reg = PROBECNT_RST;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		add_item(ACT_QUERY,  64'd0, 1, 1'b0);            // empty filter
		add_item(ACT_QUERY,  '1, 1, 1'b0);
		add_item(ACT_INSERT, 64'd0, 0, 1'b0);
		add_item(ACT_QUERY,  64'd0, 1, 1'b1);
		add_item(ACT_INSERT, '1, 0, 1'b0);
		add_item(ACT_QUERY,  '1, 1, 1'b1);
		add_item(ACT_QUERY,  64'h0123_4567_89ab_cdef, 0, 1'b0);
		add_cfg(CFG_PROBES, 32'd0);                      // no probes: always present
		add_item(ACT_QUERY,  64'hdead, 1, 1'b1);
		add_item(ACT_INSERT, 64'hbeef, 0, 1'b0);
		add_cfg(CFG_PROBES, 32'd31);                     // saturates to the maximum
		add_item(ACT_QUERY,  64'hbeef, 0, 1'b0);
		add_item(ACT_INSERT, 64'hbeef, 0, 1'b0);
		add_item(ACT_QUERY,  64'hbeef, 1, 1'b1);
		add_cfg(CFG_BITS, 32'd0);                        // zero bits acts as one bit
		add_item(ACT_INSERT, 64'd5, 0, 1'b0);
		add_item(ACT_QUERY,  64'd999, 1, 1'b1);
		add_cfg(CFG_BITS, 32'hffff_ffff);                // masked, then saturated
		add_item(ACT_QUERY,  64'd7, 0, 1'b0);
		add_cfg(CFG_NO_REG, 32'd3);                      // ignored write
		add_item(ACT_QUERY,  64'hbeef, 1, 1'b1);
		add_cfg(CFG_BITS, 32'd8);
		add_cfg(CFG_PROBES, 32'd1);
		add_item(ACT_QUERY,  64'h8000_0000_0000_0003, 0, 1'b0);
		add_item(ACT_INSERT, 64'h8000_0000_0000_0003, 0, 1'b0);
		add_item(ACT_QUERY,  64'h8000_0000_0000_0003, 1, 1'b1);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				offer_item(dir_rows[i].act, dir_rows[i].k, dir_rows[i].typed,
					dir_rows[i].want);
		end

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = (ph == 1) ? 45 : (ph == 3) ? 25 : 0;
			stall_pct = (ph == 2) ? 45 : (ph == 3) ? 25 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				write_reg(CFG_BITS, pick_bits());
				write_reg(CFG_PROBES, ($urandom_range(9) == 0) ? $urandom_range(17, 31)
					: $urandom_range(0, 16));
				for (int n = 0; n < 100; n++) begin
					act = 1'($urandom_range(1));
					k   = {$urandom, $urandom};
					// half of the queries look up a key that was put in earlier
					if (act == ACT_QUERY && inserted_keys.size() != 0 && $urandom_range(1))
						k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
					offer_item(act, k, 0, 1'b0);
				end
			end
		end

		// long receiver hold-off while queries keep coming
		gap_pct = 0; stall_pct = 0;
		write_reg(CFG_BITS, FILTER_BITS);
		write_reg(CFG_PROBES, PROBECNT_RST);
		hold_left = HOLD_CYC;
		for (int n = 0; n < 12; n++)
			offer_item(ACT_QUERY, {$urandom, $urandom}, 0, 1'b0);

		in_valid = 1'b0;
		while (answers_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
		$display("Covered %0d items (%0d queries, %0d answered present), %0d register writes,",
			n_items, n_queries, n_hits, n_cfg);
		$display("over four idle/stall mixes and one long output hold-off.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
